// ===== sv/dpes_pkg.sv =====
// shared types, constants and table builder for the damped pendulum stepper
// no dependencies; imported by every module of the block
package dpes_pkg;

  // block parameters
  localparam int unsigned SUBSTEPS        = 1000;
  localparam int unsigned SINE_TABLE_BITS = 10;

  // fixed-point widths
  localparam int unsigned StateW = 48;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned SineW  = 31;
  localparam int unsigned ProdW  = StateW + CfgW;
  localparam int unsigned HalfW  = StateW / 2;

  // sine table geometry
  localparam int unsigned SineN   = 1 << SINE_TABLE_BITS;
  localparam int unsigned SineAw  = SINE_TABLE_BITS + 1;
  localparam int unsigned PhaseW  = SINE_TABLE_BITS + 2;
  localparam int unsigned PhLow   = 31 - SINE_TABLE_BITS;
  localparam logic [32:0] PhRound = 33'(1) << (30 - SINE_TABLE_BITS);

  // substep counter
  localparam int unsigned CntW = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;

  // step size dt in unsigned Q0.48
  localparam logic [CfgW-1:0] DtQ48 = 32'd3753000;
  localparam logic [63:0] HalfPiQ62 = 64'h6487_ED51_10B4_611A;

  // register reset values
  localparam logic [CfgW-1:0] DampingRst = 32'd0;
  localparam logic [CfgW-1:0] GOverLRst  = 32'd642646;

  // saturation limits
  localparam logic [StateW-1:0] Max48 = {1'b0, {(StateW-1){1'b1}}};
  localparam logic [StateW-1:0] Min48 = {1'b1, {(StateW-1){1'b0}}};

  // stream item kinds
  localparam logic KindLoad    = 1'b0;
  localparam logic KindAdvance = 1'b1;

  // configuration register indexes
  localparam logic CfgDamping = 1'b0;
  localparam logic CfgGOverL  = 1'b1;

  typedef enum logic [1:0] {
    SH_DRAG,
    SH_GRAV,
    SH_DT
  } shift_e;

  // control of the shared multiplier
  typedef struct packed {
    logic   load;
    logic   acc;
    logic   fin;
    shift_e shift;
  } mul_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAG_LO,
    ST_DRAG_HI,
    ST_DRAG_FIN,
    ST_GRAV_LO,
    ST_GRAV_HI,
    ST_GRAV_FIN,
    ST_DA_LO,
    ST_DA_HI,
    ST_DA_FIN,
    ST_DV_LO,
    ST_DV_HI,
    ST_DV_FIN,
    ST_UPD,
    ST_DONE
  } state_e;

  typedef logic [SineW-1:0] sine_rom_t [SineN+1];

  // (a*b) >> s, low 64 bits
  function automatic logic [63:0] umul_sh(logic [63:0] a, logic [63:0] b, int unsigned s);
    logic [127:0] p;
    p = a * b;
    return p[s +: 64];
  endfunction

  // divide a taylor term by (n+1)(n+2)
  function automatic logic [63:0] taylor_div(logic [63:0] t, int unsigned n);
    logic [63:0] r;
    case (n)
      1:       r = t / 64'd6;
      3:       r = t / 64'd20;
      5:       r = t / 64'd42;
      7:       r = t / 64'd72;
      9:       r = t / 64'd110;
      11:      r = t / 64'd156;
      13:      r = t / 64'd210;
      15:      r = t / 64'd272;
      17:      r = t / 64'd342;
      19:      r = t / 64'd420;
      21:      r = t / 64'd506;
      23:      r = t / 64'd600;
      25:      r = t / 64'd702;
      default: r = t;
    endcase
    return r;
  endfunction

  // quarter-wave sine table, unsigned Q1.30 magnitudes
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   tbl;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    logic        sub;
    for (int unsigned k = 0; k <= SineN; k++) begin
      x    = umul_sh(HalfPiQ62, 64'(k), SINE_TABLE_BITS);
      x2   = umul_sh(x, x, 62);
      term = x;
      sum  = x;
      sub  = 1'b1;
      for (int unsigned n = 1; n <= 25; n += 2) begin
        term = taylor_div(umul_sh(term, x2, 62), n);
        sum  = sub ? sum - term : sum + term;
        sub  = !sub;
      end
      e = (sum + 64'h8000_0000) >> 32;
      if (e > 64'h4000_0000) e = 64'h4000_0000;
      tbl[k] = e[SineW-1:0];
    end
    return tbl;
  endfunction

  // saturating signed add
  function automatic logic [StateW-1:0] sat_add(logic [StateW-1:0] a, logic [StateW-1:0] b);
    logic [StateW:0] s;
    s = {a[StateW-1], a} + {b[StateW-1], b};
    if (s[StateW] != s[StateW-1]) return s[StateW] ? Min48 : Max48;
    return s[StateW-1:0];
  endfunction

  // saturating signed subtract
  function automatic logic [StateW-1:0] sat_sub(logic [StateW-1:0] a, logic [StateW-1:0] b);
    logic [StateW:0] s;
    s = {a[StateW-1], a} - {b[StateW-1], b};
    if (s[StateW] != s[StateW-1]) return s[StateW] ? Min48 : Max48;
    return s[StateW-1:0];
  endfunction

endpackage

// ===== sv/damped_pendulum_euler_stepper_core.sv =====
// top level: state registers, substep sequencer, config registers, output register
// depends on dpes_pkg, dpes_sine_rom and dpes_mul
//
// channel   dir  accept on              carries
// s_axis    in   tvalid & tready        tuser kind, tdata new_angle / new_velocity
// m_axis    out  tvalid & tready        tdata angle / velocity
// cfg       in   cfg_we_i               cfg_idx_i register, cfg_data_i value
//
// an advance item runs SUBSTEPS substeps, each four passes through the one shared
// multiplier (load, high-half accumulate and final states) plus the state update;
// a load item goes straight to the hand-over state
// reset clears angle and velocity to zero and the registers to their defaults
// tready is low while an item runs; a result waiting in the output register
// holds the next item only at its hand-over

module damped_pendulum_euler_stepper_core
  import dpes_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [47:0] new_angle, [95:48] new_velocity
  input  logic [2*StateW-1:0] s_axis_tdata,
  // [0] kind
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [47:0] angle, [95:48] velocity
  output logic [2*StateW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  state_e              state_q, state_d;
  logic [StateW-1:0]   angle_q, vel_q;
  logic [StateW-1:0]   drag_q, acc_q, da_q;
  logic [CntW-1:0]     cnt_q;
  logic [CfgW-1:0]     damping_q, g_q;
  logic                out_valid_q;
  logic [2*StateW-1:0] out_q;
  logic                in_fire, out_free, last_step;

  mul_ctl_t            mctl;
  logic [StateW-1:0]   m_mag;
  logic                m_neg;
  logic [CfgW-1:0]     m_b;
  logic [StateW-1:0]   m_res;

  logic [32:0]         ph_sum;
  logic [PhaseW-1:0]   phase;
  logic [SineAw-1:0]   rom_addr;
  logic [SineW-1:0]    rom_mag;
  logic                rom_neg;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign last_step = (cnt_q == CntW'(SUBSTEPS - 1));

  // sine phase from the current angle
  always_comb begin
    ph_sum   = angle_q[32:0] + PhRound;
    phase    = ph_sum[32:PhLow];
    rom_addr = phase[SINE_TABLE_BITS]
             ? SineAw'(SineN) - {1'b0, phase[SINE_TABLE_BITS-1:0]}
             : {1'b0, phase[SINE_TABLE_BITS-1:0]};
  end

  dpes_sine_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .neg_i  (phase[PhaseW-1]),
    .mag_o  (rom_mag),
    .neg_o  (rom_neg)
  );

  dpes_mul u_mul (
    .clk_i (clk_i),
    .ctl_i (mctl),
    .mag_i (m_mag),
    .neg_i (m_neg),
    .b_i   (m_b),
    .res_o (m_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = (s_axis_tuser == KindLoad) ? ST_DONE : ST_DRAG_LO;
      end
      ST_DRAG_LO:  state_d = ST_DRAG_HI;
      ST_DRAG_HI:  state_d = ST_DRAG_FIN;
      ST_DRAG_FIN: state_d = ST_GRAV_LO;
      ST_GRAV_LO:  state_d = ST_GRAV_HI;
      ST_GRAV_HI:  state_d = ST_GRAV_FIN;
      ST_GRAV_FIN: state_d = ST_DA_LO;
      ST_DA_LO:    state_d = ST_DA_HI;
      ST_DA_HI:    state_d = ST_DA_FIN;
      ST_DA_FIN:   state_d = ST_DV_LO;
      ST_DV_LO:    state_d = ST_DV_HI;
      ST_DV_HI:    state_d = ST_DV_FIN;
      ST_DV_FIN:   state_d = ST_UPD;
      ST_UPD:      state_d = last_step ? ST_DONE : ST_DRAG_LO;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // multiplier control and operands
  always_comb begin
    mctl  = '{load: 1'b0, acc: 1'b0, fin: 1'b0, shift: SH_DT};
    m_mag = vel_q[StateW-1] ? -vel_q : vel_q;
    m_neg = vel_q[StateW-1];
    m_b   = DtQ48;
    s_axis_tready = (state_q == ST_IDLE);
    unique case (state_q)
      ST_DRAG_LO: begin
        mctl.load = 1'b1;
        m_b       = damping_q;
      end
      ST_GRAV_LO: begin
        mctl.load = 1'b1;
        m_mag     = {{(StateW-SineW){1'b0}}, rom_mag};
        m_neg     = rom_neg;
        m_b       = g_q;
      end
      ST_DA_LO: mctl.load = 1'b1;
      ST_DV_LO: begin
        mctl.load = 1'b1;
        m_mag     = acc_q[StateW-1] ? -acc_q : acc_q;
        m_neg     = acc_q[StateW-1];
      end
      ST_DRAG_HI, ST_GRAV_HI, ST_DA_HI, ST_DV_HI: mctl.acc = 1'b1;
      ST_DRAG_FIN: begin
        mctl.fin   = 1'b1;
        mctl.shift = SH_DRAG;
      end
      ST_GRAV_FIN: begin
        mctl.fin   = 1'b1;
        mctl.shift = SH_GRAV;
      end
      ST_DA_FIN, ST_DV_FIN: mctl.fin = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      angle_q     <= '0;
      vel_q       <= '0;
      cnt_q       <= '0;
      damping_q   <= DampingRst;
      g_q         <= GOverLRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // config writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgDamping: damping_q <= cfg_data_i;
          default:    g_q       <= cfg_data_i;
        endcase
      end
      // state load and update
      if (in_fire) begin
        cnt_q <= '0;
        if (s_axis_tuser == KindLoad) begin
          angle_q <= s_axis_tdata[StateW-1:0];
          vel_q   <= s_axis_tdata[2*StateW-1:StateW];
        end
      end
      if (state_q == ST_UPD) begin
        angle_q <= sat_add(angle_q, da_q);
        vel_q   <= sat_sub(vel_q, m_res);
        cnt_q   <= cnt_q + 1'b1;
      end
      // output handshake
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // intermediate terms and output payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_GRAV_LO) drag_q <= m_res;
    if (state_q == ST_DA_LO)   acc_q  <= sat_add(drag_q, m_res);
    if (state_q == ST_DV_LO)   da_q   <= m_res;
    if (state_q == ST_DONE && out_free) out_q <= {vel_q, angle_q};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== sv/dpes_sine_rom.sv =====
// quarter-wave sine lookup with registered read
// depends on dpes_pkg for the table builder and widths
module dpes_sine_rom
  import dpes_pkg::*;
(
  input  logic              clk_i,
  input  logic [SineAw-1:0] addr_i,
  input  logic              neg_i,
  output logic [SineW-1:0]  mag_o,
  output logic              neg_o
);

  localparam sine_rom_t Rom = build_sine_rom();

  // registered read, sign carried alongside
  always_ff @(posedge clk_i) begin
    mag_o <= Rom[addr_i];
    neg_o <= neg_i;
  end

endmodule

// ===== sv/dpes_mul.sv =====
// shared sign-magnitude multiplier: 48x32 in two 24x32 halves, then shift and saturate
// depends on dpes_pkg for widths and the control struct
module dpes_mul
  import dpes_pkg::*;
(
  input  logic              clk_i,
  input  mul_ctl_t          ctl_i,
  input  logic [StateW-1:0] mag_i,
  input  logic              neg_i,
  input  logic [CfgW-1:0]   b_i,
  output logic [StateW-1:0] res_o
);

  logic [StateW-1:0]      mag_q;
  logic                   neg_q;
  logic [CfgW-1:0]        b_q;
  logic [HalfW+CfgW-1:0]  plo_q;
  logic [HalfW+CfgW-1:0]  phi;
  logic [ProdW-1:0]       prod_q;
  logic [StateW-1:0]      res_q;
  logic [ProdW-1:0]       sh;
  logic [StateW-1:0]      limit;
  logic [StateW-1:0]      clip;

  // upper half partial product at full width
  assign phi = mag_q[StateW-1:HalfW] * b_q;

  // shift and clamp to the limit for the sign
  always_comb begin
    case (ctl_i.shift)
      SH_DRAG: sh = prod_q >> 24;
      SH_GRAV: sh = prod_q >> 14;
      default: sh = prod_q >> 48;
    endcase
    limit = neg_q ? Min48 : Max48;
    clip  = (sh > {{(ProdW-StateW){1'b0}}, limit}) ? limit : sh[StateW-1:0];
  end

  // low half, high half with accumulate, final
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      mag_q <= mag_i;
      neg_q <= neg_i;
      b_q   <= b_i;
      plo_q <= mag_i[HalfW-1:0] * b_i;
    end
    if (ctl_i.acc) begin
      prod_q <= {{(ProdW-HalfW-CfgW){1'b0}}, plo_q}
              + ({{(ProdW-HalfW-CfgW){1'b0}}, phi} << HalfW);
    end
    if (ctl_i.fin) begin
      res_q <= neg_q ? -clip : clip;
    end
  end

  assign res_o = res_q;

endmodule

// ===== sv/dpes_checker.sv =====
// port-level checks for the pendulum stepper, bound to the top level
// depends on dpes_pkg for widths
module dpes_checker
  import dpes_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [2*StateW-1:0] m_axis_tdata
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its data
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // busy right after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after accept");

  // a new result appears only at the end of an item
  a_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result without an item in flight");

endmodule

bind damped_pendulum_euler_stepper_core dpes_checker u_dpes_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/damped_pendulum_euler_stepper_core_tb.sv =====
// stream testbench for the damped pendulum euler stepper core
// depends on dpes_pkg and damped_pendulum_euler_stepper_core; self-checking by a pendulum model
module damped_pendulum_euler_stepper_core_tb;
  import dpes_pkg::*;

  typedef logic [StateW-1:0] st_t;

  // expected state store and pendulum model with its own copy of state and registers
  class pendulum_tracker;
    logic [63:0] sine_q30_tbl [SineN+1];
    st_t         angle_q;
    st_t         vel_q;
    logic [31:0] damp_q;
    logic [31:0] gl_q;
    st_t         exp_angle [$];
    st_t         exp_vel [$];
    int          mismatches;

    function new();
      logic [127:0] p;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  e;
      logic         sub;
      angle_q    = '0;
      vel_q      = '0;
      damp_q     = 32'd0;
      gl_q       = 32'd642646;
      mismatches = 0;
      // quarter-wave table from the odd taylor series in Q2.62
      for (int k = 0; k <= SineN; k++) begin
        p    = {64'd0, HalfPiQ62} * 128'(k);
        x    = 64'(p >> SINE_TABLE_BITS);
        p    = {64'd0, x} * {64'd0, x};
        x2   = 64'(p >> 62);
        term = x;
        sum  = x;
        sub  = 1'b1;
        for (int n = 1; n <= 25; n += 2) begin
          p    = {64'd0, term} * {64'd0, x2};
          term = 64'(p >> 62) / 64'((n + 1) * (n + 2));
          sum  = sub ? sum - term : sum + term;
          sub  = !sub;
        end
        e = (sum + 64'h8000_0000) >> 32;
        if (e > 64'h4000_0000) e = 64'h4000_0000;
        sine_q30_tbl[k] = e;
      end
    endfunction

    function st_t clamp(logic signed [StateW+1:0] v);
      if (v > $signed({3'b000, {(StateW-1){1'b1}}})) return {1'b0, {(StateW-1){1'b1}}};
      if (v < $signed({3'b111, {(StateW-1){1'b0}}})) return {1'b1, {(StateW-1){1'b0}}};
      return v[StateW-1:0];
    endfunction

    // signed times unsigned, shifted, magnitude truncated and saturated
    function st_t scaled(st_t a, logic [31:0] b, int sh);
      logic         neg;
      st_t          m;
      st_t          lim;
      logic [127:0] q;
      neg = a[StateW-1];
      m   = neg ? -a : a;
      lim = neg ? {1'b1, {(StateW-1){1'b0}}} : {1'b0, {(StateW-1){1'b1}}};
      q   = ({80'd0, m} * {96'd0, b}) >> sh;
      if (q > {80'd0, lim}) q = {80'd0, lim};
      return neg ? -q[StateW-1:0] : q[StateW-1:0];
    endfunction

    function st_t sine_of(st_t ang);
      logic [63:0] u;
      logic [11:0] ph;
      logic [63:0] v;
      u  = {{16{ang[StateW-1]}}, ang} + (64'd1 << (30 - SINE_TABLE_BITS));
      ph = 12'((u >> (31 - SINE_TABLE_BITS)) & 64'(4 * SineN - 1));
      v  = ph[10] ? sine_q30_tbl[SineN - ph[9:0]] : sine_q30_tbl[ph[9:0]];
      return ph[11] ? -v[StateW-1:0] : v[StateW-1:0];
    endfunction

    function void write_reg(logic idx, logic [31:0] val);
      if (idx == CfgDamping) damp_q = val;
      else gl_q = val;
    endfunction

    // accepted input beat: update the state and queue the result
    function void note_input(logic kind, st_t na, st_t nv);
      st_t a0;
      st_t v0;
      st_t acc;
      if (kind == KindLoad) begin
        angle_q = na;
        vel_q   = nv;
      end else begin
        for (int s = 0; s < SUBSTEPS; s++) begin
          a0      = angle_q;
          v0      = vel_q;
          acc     = clamp($signed(scaled(v0, damp_q, 24)) + $signed(scaled(sine_of(a0), gl_q, 14)));
          angle_q = clamp($signed(a0) + $signed(scaled(v0, DtQ48, 48)));
          vel_q   = clamp($signed(v0) - $signed(scaled(acc, DtQ48, 48)));
        end
      end
      exp_angle = {exp_angle, angle_q};
      exp_vel   = {exp_vel, vel_q};
    endfunction

    // accepted output beat: compare with the oldest expected state
    function void check_result(logic [2*StateW-1:0] d);
      st_t ea;
      st_t ev;
      if (exp_angle.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", d);
        return;
      end
      ea = exp_angle.pop_front();
      ev = exp_vel.pop_front();
      if (d[StateW-1:0] !== ea || d[2*StateW-1:StateW] !== ev) begin
        mismatches++;
        if (mismatches <= 10)
          $display("state mismatch: exp angle %h vel %h, got angle %h vel %h",
                   ea, ev, d[StateW-1:0], d[2*StateW-1:StateW]);
      end
    endfunction

    function int pending();
      return exp_angle.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [2*StateW-1:0] s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [2*StateW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [CfgW-1:0]     cfg_data_i;

  pendulum_tracker tracker;
  int              cycles;
  int              stall_left;
  int              hold_left;
  bit              calm;

  damped_pendulum_euler_stepper_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // beat monitor on both sides
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        tracker.note_input(s_axis_tuser, s_axis_tdata[StateW-1:0],
                           s_axis_tdata[2*StateW-1:StateW]);
      if (m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
    end
  end

  // receiver: random stall bursts and one long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic drive_item(logic kind, st_t na, st_t nv);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {nv, na};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // register write once the input is idle and every expected state has come back
  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    tracker.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic st_t pick_value(bit tame);
    int sel;
    sel = tame ? 4 : $urandom_range(0, 5);
    case (sel)
      0:       return {1'b0, {(StateW-1){1'b1}}};
      1:       return {1'b1, {(StateW-1){1'b0}}};
      2:       return '0;
      3:       return st_t'({$urandom, $urandom});
      default: return st_t'($signed({$urandom, $urandom}) >>> 29);
    endcase
  endfunction

  // random items: mostly loads, advances are costly
  task automatic run_random(int count, int loads_first);
    logic kind;
    for (int n = 0; n < count; n++) begin
      kind = (n >= loads_first && $urandom_range(0, 4) == 0) ? KindAdvance : KindLoad;
      drive_item(kind, pick_value($urandom_range(0, 2) != 0), pick_value($urandom_range(0, 2) != 0));
    end
  endtask

  initial begin
    tracker       = new();
    cycles        = 0;
    stall_left    = 0;
    hold_left     = 0;
    calm          = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = KindLoad;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgDamping;
    cfg_data_i    = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: rest, extremes, saturation, ignored load fields, large angles
    drive_item(KindAdvance, '1, '1);
    drive_item(KindLoad, 48'h0000_8000_0000, '0);
    drive_item(KindAdvance, '0, '0);
    drive_item(KindLoad, {1'b0, {(StateW-1){1'b1}}}, {1'b0, {(StateW-1){1'b1}}});
    drive_item(KindAdvance, {1'b1, {(StateW-1){1'b0}}}, '0);
    drive_item(KindLoad, {1'b1, {(StateW-1){1'b0}}}, {1'b1, {(StateW-1){1'b0}}});
    drive_item(KindAdvance, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
    drive_item(KindLoad, 48'h03E8_4000_0000, 48'hFFFE_0000_0000);
    drive_item(KindAdvance, '0, '0);
    drive_item(KindLoad, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0001);

    // settings: unit damping at default g/L, both maxima, both zero, random, half damping calm
    write_reg(CfgDamping, 32'h0100_0000);
    write_reg(CfgGOverL, 32'd642646);
    run_random(20, 0);

    write_reg(CfgDamping, 32'hFFFF_FFFF);
    write_reg(CfgGOverL, 32'hFFFF_FFFF);
    hold_left = 400;
    run_random(25, 8);

    write_reg(CfgDamping, 32'd0);
    write_reg(CfgGOverL, 32'd0);
    run_random(25, 0);

    write_reg(CfgDamping, $urandom);
    write_reg(CfgGOverL, $urandom_range(0, 32'h00FF_FFFF));
    run_random(35, 0);

    write_reg(CfgDamping, 32'h0080_0000);
    write_reg(CfgGOverL, 32'd642646);
    calm = 1'b1;
    run_random(35, 0);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (tracker.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
